/* rtl/kmwt_pkg.sv */
// Shared types, constants and helper functions of the k-way merge winner tree.
// Used by every module of the block but kmwt_ram; depends on nothing else.

package kmwt_pkg;

    // Sizing of the way FIFOs and the stored data
    localparam int WAYS        = 8;
    localparam int FIFO_DEPTH  = 16;
    localparam int DATA_WIDTH  = 32;

    localparam int WAY_W       = $clog2(WAYS);
    localparam int PTR_W       = $clog2(FIFO_DEPTH);
    localparam int CNT_W       = $clog2(FIFO_DEPTH + 1);
    localparam int ACT_W       = $clog2(WAYS + 1);
    localparam int STORE_DEPTH = WAYS * FIFO_DEPTH;
    localparam int ADDR_W      = $clog2(STORE_DEPTH);

    // Fixed widths of the request and result fields
    localparam int OP_W        = 1;
    localparam int IN_WAY_W    = 3;
    localparam int VAL_W       = 32;
    localparam int OUT_WAY_W   = 3;
    localparam int STAT_W      = 2;
    localparam int CFG_W       = 4;
    localparam int CFG_RESET   = 8;

    localparam int IN_TDATA_W  = ((IN_WAY_W + VAL_W + 7) / 8) * 8;
    localparam int OUT_FIELD_W = VAL_W + OUT_WAY_W + STAT_W;
    localparam int OUT_TDATA_W = ((OUT_FIELD_W + 7) / 8) * 8;
    localparam int OUT_PAD_W   = OUT_TDATA_W - OUT_FIELD_W;

    typedef enum logic [OP_W-1:0] {
        OP_PUSH = 1'b0,
        OP_POP  = 1'b1
    } t_op;

    typedef enum logic [STAT_W-1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2,
        ST_RANGE = 2'd3
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_PUSH,
        S_SCAN,
        S_EVAL,
        S_POP,
        S_DONE
    } t_state;

    // Way table read port: state of the addressed way
    typedef struct packed {
        logic             live;
        logic [PTR_W-1:0] head;
        logic [CNT_W-1:0] count;
    } t_tbl_rd;

    // Way table write port
    typedef struct packed {
        logic             en;
        logic [WAY_W-1:0] way;
        logic [PTR_W-1:0] head;
        logic [CNT_W-1:0] count;
    } t_tbl_wr;

    // One way's head read issued during the scan
    typedef struct packed {
        logic             vld;
        logic             live;
        logic [WAY_W-1:0] way;
        logic [PTR_W-1:0] head;
        logic [CNT_W-1:0] count;
    } t_scan;

    // Current winner of the scan
    typedef struct packed {
        logic                  vld;
        logic [WAY_W-1:0]      way;
        logic [DATA_WIDTH-1:0] val;
        logic [PTR_W-1:0]      head;
        logic [CNT_W-1:0]      count;
    } t_best;

    // Flat store address of one entry of one way
    function automatic logic [ADDR_W-1:0] store_addr(input logic [WAY_W-1:0] way,
                                                     input logic [PTR_W-1:0] ptr);
        return ADDR_W'(int'(way) * FIFO_DEPTH + int'(ptr));
    endfunction

    // Advance a read pointer with wrap
    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] ptr);
        logic [PTR_W-1:0] res;
        if (int'(ptr) == FIFO_DEPTH - 1) begin
            res = '0;
        end else begin
            res = PTR_W'(int'(ptr) + 1);
        end
        return res;
    endfunction

    // Write position behind the last held entry
    function automatic logic [PTR_W-1:0] tail_ptr(input logic [PTR_W-1:0] head,
                                                  input logic [CNT_W-1:0] count);
        int sum;
        sum = int'(head) + int'(count);
        if (sum >= FIFO_DEPTH) begin
            sum = sum - FIFO_DEPTH;
        end
        return PTR_W'(sum);
    endfunction

    // Sign-extend a request value and keep its low stored bits
    function automatic logic [DATA_WIDTH-1:0] to_store(input logic [VAL_W-1:0] v);
        logic signed [63:0] ext;
        ext = 64'(signed'(v));
        return ext[DATA_WIDTH-1:0];
    endfunction

    // Sign-extend a stored value and keep the result width
    function automatic logic [VAL_W-1:0] from_store(input logic [DATA_WIDTH-1:0] d);
        logic signed [63:0] ext;
        ext = 64'(signed'(d));
        return ext[VAL_W-1:0];
    endfunction

endpackage

/* rtl/kway_merge_winner_tree.sv */
// K-way merge top level: sequencer, request and result registers.
// Depends on kmwt_pkg, kmwt_ram, kmwt_way_tbl, kmwt_min_unit and kmwt_port_chk.
// Sequence: a push steps through PUSH and DONE after the request is taken;
// a pop steps through SCAN (one way head read per way in use), EVAL, POP and DONE.
// A new request is taken only in IDLE, after DONE has loaded the result; a stalled result holds DONE.
// Reset (synchronous) clears control state and fill levels; no clearing pass.

module kway_merge_winner_tree (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    // Configuration: ways_in_use
    input  logic                               i_cfg_valid,
    output logic                               o_cfg_ready,
    input  logic [kmwt_pkg::CFG_W-1:0]         i_cfg_data,
    // Requests
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    input  logic [kmwt_pkg::IN_TDATA_W-1:0]    s_axis_tdata,  // way_index, value
    input  logic [kmwt_pkg::OP_W-1:0]          s_axis_tuser,  // operation
    // Results
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    output logic [kmwt_pkg::OUT_TDATA_W-1:0]   m_axis_tdata   // merged_value, source_way, status
);

    kmwt_pkg::t_state                  r_state, n_state;
    logic [kmwt_pkg::CFG_W-1:0]        r_cfg;
    logic [kmwt_pkg::ACT_W-1:0]        act;
    logic                              r_in_op;
    logic [kmwt_pkg::IN_WAY_W-1:0]     r_in_way;
    logic [kmwt_pkg::VAL_W-1:0]        r_in_val;
    logic [kmwt_pkg::WAY_W-1:0]        r_way, n_way;
    logic [kmwt_pkg::VAL_W-1:0]        r_res_val, n_res_val;
    logic [kmwt_pkg::OUT_WAY_W-1:0]    r_res_way, n_res_way;
    kmwt_pkg::t_status                 r_res_status, n_res_status;
    logic                              r_out_vld, n_out_vld;
    logic [kmwt_pkg::OUT_TDATA_W-1:0]  r_out_data, n_out_data;

    logic                              req_take;
    logic                              out_free;
    logic                              scan_last;
    logic                              in_range;
    logic                              fifo_full;
    logic                              ram_we;
    logic [kmwt_pkg::ADDR_W-1:0]       ram_waddr;
    logic [kmwt_pkg::DATA_WIDTH-1:0]   ram_wdata;
    logic [kmwt_pkg::ADDR_W-1:0]       ram_raddr;
    logic [kmwt_pkg::DATA_WIDTH-1:0]   ram_rdata;
    kmwt_pkg::t_tbl_rd                 tbl_rd;
    kmwt_pkg::t_tbl_wr                 tbl_wr;
    kmwt_pkg::t_scan                   issue;
    kmwt_pkg::t_best                   best;

    assign o_cfg_ready   = 1'b1;
    assign s_axis_tready = (r_state == kmwt_pkg::S_IDLE);
    assign req_take      = s_axis_tvalid && s_axis_tready;
    assign out_free      = !r_out_vld || m_axis_tready;
    assign m_axis_tvalid = r_out_vld;
    assign m_axis_tdata  = r_out_data;

    // Configuration register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= kmwt_pkg::CFG_W'(kmwt_pkg::CFG_RESET);
        end else if (i_cfg_valid) begin
            r_cfg <= i_cfg_data;
        end
    end

    // Clamp ways in use to 1 .. WAYS
    always_comb begin
        if (r_cfg == '0) begin
            act = kmwt_pkg::ACT_W'(1);
        end else if (int'(r_cfg) > kmwt_pkg::WAYS) begin
            act = kmwt_pkg::ACT_W'(kmwt_pkg::WAYS);
        end else begin
            act = kmwt_pkg::ACT_W'(r_cfg);
        end
    end

    assign scan_last = (int'(r_way) == int'(act) - 1);
    assign in_range  = (int'(r_in_way) < int'(act));
    assign fifo_full = (int'(tbl_rd.count) == kmwt_pkg::FIFO_DEPTH);

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            kmwt_pkg::S_IDLE: begin
                if (req_take) begin
                    n_state = (s_axis_tuser == kmwt_pkg::OP_POP) ?
                              kmwt_pkg::S_SCAN : kmwt_pkg::S_PUSH;
                end
            end
            kmwt_pkg::S_PUSH: n_state = kmwt_pkg::S_DONE;
            kmwt_pkg::S_SCAN: begin
                if (scan_last) begin
                    n_state = kmwt_pkg::S_EVAL;
                end
            end
            kmwt_pkg::S_EVAL: n_state = kmwt_pkg::S_POP;
            kmwt_pkg::S_POP:  n_state = kmwt_pkg::S_DONE;
            kmwt_pkg::S_DONE: begin
                if (out_free) begin
                    n_state = kmwt_pkg::S_IDLE;
                end
            end
            default: n_state = kmwt_pkg::S_IDLE;
        endcase
    end

    // Sequencer outputs: store and table updates, result and scan index
    always_comb begin
        ram_we       = 1'b0;
        ram_waddr    = kmwt_pkg::store_addr(r_way, kmwt_pkg::tail_ptr(tbl_rd.head,
                                                                      tbl_rd.count));
        ram_wdata    = kmwt_pkg::to_store(r_in_val);
        ram_raddr    = kmwt_pkg::store_addr(r_way, tbl_rd.head);
        tbl_wr       = '0;
        issue.vld    = 1'b0;
        issue.live   = tbl_rd.live;
        issue.way    = r_way;
        issue.head   = tbl_rd.head;
        issue.count  = tbl_rd.count;
        n_way        = r_way;
        n_res_val    = r_res_val;
        n_res_way    = r_res_way;
        n_res_status = r_res_status;
        n_out_vld    = r_out_vld && !m_axis_tready;
        n_out_data   = r_out_data;
        unique case (r_state)
            kmwt_pkg::S_IDLE: begin
                if (req_take) begin
                    if (s_axis_tuser == kmwt_pkg::OP_POP) begin
                        n_way = '0;
                    end else begin
                        n_way = kmwt_pkg::WAY_W'(
                            s_axis_tdata[kmwt_pkg::IN_WAY_W-1:0]);
                    end
                end
            end
            kmwt_pkg::S_PUSH: begin
                n_res_val = '0;
                n_res_way = '0;
                if (!in_range) begin
                    n_res_status = kmwt_pkg::ST_RANGE;
                end else if (fifo_full) begin
                    n_res_status = kmwt_pkg::ST_FULL;
                end else begin
                    n_res_status = kmwt_pkg::ST_OK;
                    ram_we       = 1'b1;
                    tbl_wr.en    = 1'b1;
                    tbl_wr.way   = r_way;
                    tbl_wr.head  = tbl_rd.head;
                    tbl_wr.count = kmwt_pkg::CNT_W'(int'(tbl_rd.count) + 1);
                end
            end
            kmwt_pkg::S_SCAN: begin
                // Read this way's head; the compare follows once the read data is registered
                issue.vld = 1'b1;
                if (!scan_last) begin
                    n_way = kmwt_pkg::WAY_W'(int'(r_way) + 1);
                end
            end
            kmwt_pkg::S_EVAL: begin
                // Last head is folded in at this edge
            end
            kmwt_pkg::S_POP: begin
                if (best.vld) begin
                    n_res_val    = kmwt_pkg::from_store(best.val);
                    n_res_way    = kmwt_pkg::OUT_WAY_W'(best.way);
                    n_res_status = kmwt_pkg::ST_OK;
                    tbl_wr.en    = 1'b1;
                    tbl_wr.way   = best.way;
                    tbl_wr.head  = kmwt_pkg::ptr_inc(best.head);
                    tbl_wr.count = kmwt_pkg::CNT_W'(int'(best.count) - 1);
                end else begin
                    n_res_val    = '0;
                    n_res_way    = '0;
                    n_res_status = kmwt_pkg::ST_EMPTY;
                end
            end
            kmwt_pkg::S_DONE: begin
                if (out_free) begin
                    n_out_vld  = 1'b1;
                    n_out_data = {{kmwt_pkg::OUT_PAD_W{1'b0}}, r_res_status,
                                  r_res_way, r_res_val};
                end
            end
            default: begin
            end
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= kmwt_pkg::S_IDLE;
            r_out_vld <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_out_vld <= n_out_vld;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        if (req_take) begin
            r_in_op  <= s_axis_tuser;
            r_in_way <= s_axis_tdata[kmwt_pkg::IN_WAY_W-1:0];
            r_in_val <= s_axis_tdata[kmwt_pkg::IN_WAY_W +: kmwt_pkg::VAL_W];
        end
        r_way        <= n_way;
        r_res_val    <= n_res_val;
        r_res_way    <= n_res_way;
        r_res_status <= n_res_status;
        r_out_data   <= n_out_data;
    end

    kmwt_ram #(
        .WIDTH (kmwt_pkg::DATA_WIDTH),
        .DEPTH (kmwt_pkg::STORE_DEPTH)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    kmwt_way_tbl u_way_tbl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_act    (act),
        .i_rd_way (r_way),
        .o_rd     (tbl_rd),
        .i_wr     (tbl_wr)
    );

    kmwt_min_unit u_min (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_clear   (req_take),
        .i_issue   (issue),
        .i_rd_data (ram_rdata),
        .o_best    (best)
    );

    // Check the result channel protocol
    kmwt_port_chk u_port_chk (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_m_tvalid (m_axis_tvalid),
        .i_m_tready (m_axis_tready),
        .i_m_tdata  (m_axis_tdata)
    );

    // Pushes only reach the sequencer through the push request path
    a_push_op: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == kmwt_pkg::S_PUSH) |-> (r_in_op == kmwt_pkg::OP_PUSH))
        else $error("push step entered for a pop request");

    // A result is loaded only from the finishing step
    a_out_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_vld) |-> $past(r_state == kmwt_pkg::S_DONE))
        else $error("result loaded outside the finishing step");

    // A pop without any live head reports all ways empty
    a_empty_pop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == kmwt_pkg::S_POP && !best.vld) |=>
        (r_res_status == kmwt_pkg::ST_EMPTY))
        else $error("empty pop not flagged");

endmodule

/* rtl/kmwt_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// Stand-alone; holds the value store of all way FIFOs.

module kmwt_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 128
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port and registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

/* rtl/kmwt_way_tbl.sv */
// Per-way read pointers and fill levels of the way FIFOs.
// Depends on kmwt_pkg for sizes and the read and write port structs.

module kmwt_way_tbl (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic [kmwt_pkg::ACT_W-1:0]    i_act,
    input  logic [kmwt_pkg::WAY_W-1:0]    i_rd_way,
    output kmwt_pkg::t_tbl_rd             o_rd,
    input  kmwt_pkg::t_tbl_wr             i_wr
);

    logic [kmwt_pkg::PTR_W-1:0] r_head  [kmwt_pkg::WAYS];
    logic [kmwt_pkg::CNT_W-1:0] r_count [kmwt_pkg::WAYS];

    // Update one way; clear every way on reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int w = 0; w < kmwt_pkg::WAYS; w++) begin
                r_head[w]  <= '0;
                r_count[w] <= '0;
            end
        end else if (i_wr.en) begin
            r_head[i_wr.way]  <= i_wr.head;
            r_count[i_wr.way] <= i_wr.count;
        end
    end

    // A way is live when it takes part and holds something
    always_comb begin
        o_rd.head  = r_head[i_rd_way];
        o_rd.count = r_count[i_rd_way];
        o_rd.live  = (r_count[i_rd_way] != '0) && (int'(i_rd_way) < int'(i_act));
    end

    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_wr.en |-> (int'(i_wr.count) <= kmwt_pkg::FIFO_DEPTH))
        else $error("way fill level written beyond FIFO depth");

endmodule

/* rtl/kmwt_min_unit.sv */
// Shared compare unit: folds one way head per cycle into the running winner.
// Depends on kmwt_pkg for the scan and winner structs.

module kmwt_min_unit (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_clear,
    input  kmwt_pkg::t_scan                   i_issue,
    input  logic [kmwt_pkg::DATA_WIDTH-1:0]   i_rd_data,
    output kmwt_pkg::t_best                   o_best
);

    kmwt_pkg::t_scan r_stage;
    kmwt_pkg::t_best r_best;
    logic            take;

    // Strictly smaller replaces, so on a tie the earlier (lower) way stays
    assign take = r_stage.vld && r_stage.live &&
                  (!r_best.vld || ($signed(i_rd_data) < $signed(r_best.val)));

    // Hold the issued way while its head is read
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stage.vld <= 1'b0;
        end else begin
            r_stage.vld <= i_issue.vld;
        end
        r_stage.live  <= i_issue.live;
        r_stage.way   <= i_issue.way;
        r_stage.head  <= i_issue.head;
        r_stage.count <= i_issue.count;
    end

    // Track the winner
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_clear) begin
            r_best.vld <= 1'b0;
        end else if (take) begin
            r_best.vld <= 1'b1;
        end
        if (take) begin
            r_best.way   <= r_stage.way;
            r_best.val   <= i_rd_data;
            r_best.head  <= r_stage.head;
            r_best.count <= r_stage.count;
        end
    end

    assign o_best = r_best;

    a_best_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_best.vld |-> (r_best.count != '0))
        else $error("winner taken from an empty way");

endmodule

/* rtl/kmwt_way_merge_winner_tree_dummy_guard.sv */
// Result channel protocol check of the merge block.
// Depends on kmwt_pkg for the field widths only.

module kmwt_port_chk (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_m_tvalid,
    input  logic                               i_m_tready,
    input  logic [kmwt_pkg::OUT_TDATA_W-1:0]   i_m_tdata
);

    // A stalled result keeps its data
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_m_tvalid && !i_m_tready) |=> (i_m_tvalid && $stable(i_m_tdata)))
        else $error("stalled result changed");

    // Padding bits of the result stay zero
    a_pad: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_m_tvalid |-> (i_m_tdata[kmwt_pkg::OUT_TDATA_W-1:kmwt_pkg::OUT_FIELD_W] == '0))
        else $error("result padding not zero");

endmodule

/* bench/testbench.sv */
// Self-checking bench for kway_merge_winner_tree: push and pop requests
// checked against a behavioural merge predictor. Depends on kmwt_pkg and the RTL.
`timescale 1ns / 100ps

module testbench;

    typedef enum {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} t_idle_mode;
    typedef enum {ROW_REQ, ROW_CFG} t_row_kind;

    typedef struct packed {
        logic [kmwt_pkg::VAL_W-1:0]     value;
        logic [kmwt_pkg::OUT_WAY_W-1:0] way;
        kmwt_pkg::t_status              status;
    } t_merge_result;

    typedef struct {
        t_row_kind                      kind;
        kmwt_pkg::t_op                  op;
        logic [kmwt_pkg::IN_WAY_W-1:0]  way;
        logic [kmwt_pkg::VAL_W-1:0]     value;   // way count on a register row
        int                             reps;
        bit                             typed;
        t_merge_result                  exp;
    } t_stim_row;

    localparam int N_ROWS      = 17;
    localparam int N_PHASES    = 8;
    localparam int PHASE_ITEMS = 215;

    // Way count and push share of each random phase
    localparam int PHASE_WAYS [N_PHASES] = '{8, 1, 15, 3, 0, 6, 8, 2};
    localparam int PHASE_PUSH [N_PHASES] = '{60, 70, 55, 65, 45, 60, 35, 50};

    // Directed part: typed expectations only where the answer is obvious
    t_stim_row plan_rows [N_ROWS] = '{
        '{ROW_REQ, kmwt_pkg::OP_POP,  3'd0, 32'h0000_0000, 1,  1'b1,
          '{32'h0, 3'd0, kmwt_pkg::ST_EMPTY}},
        '{ROW_REQ, kmwt_pkg::OP_PUSH, 3'd7, 32'h7FFF_FFFF, 1,  1'b1,
          '{32'h0, 3'd0, kmwt_pkg::ST_OK}},
        '{ROW_REQ, kmwt_pkg::OP_PUSH, 3'd0, 32'h8000_0000, 1,  1'b1,
          '{32'h0, 3'd0, kmwt_pkg::ST_OK}},
        '{ROW_REQ, kmwt_pkg::OP_PUSH, 3'd3, 32'h8000_0000, 1,  1'b1,
          '{32'h0, 3'd0, kmwt_pkg::ST_OK}},
        '{ROW_REQ, kmwt_pkg::OP_POP,  3'd0, 32'h0000_0000, 1,  1'b1,
          '{32'h8000_0000, 3'd0, kmwt_pkg::ST_OK}},
        '{ROW_REQ, kmwt_pkg::OP_POP,  3'd0, 32'h0000_0000, 1,  1'b1,
          '{32'h8000_0000, 3'd3, kmwt_pkg::ST_OK}},
        '{ROW_REQ, kmwt_pkg::OP_PUSH, 3'd5, 32'hAAAA_AAAA, 1,  1'b0,
          '{32'h0, 3'd0, kmwt_pkg::ST_OK}},
        '{ROW_REQ, kmwt_pkg::OP_POP,  3'd7, 32'hFFFF_FFFF, 1,  1'b0,
          '{32'h0, 3'd0, kmwt_pkg::ST_OK}},
        '{ROW_CFG, kmwt_pkg::OP_PUSH, 3'd0, 32'd0,         1,  1'b0,
          '{32'h0, 3'd0, kmwt_pkg::ST_OK}},
        '{ROW_REQ, kmwt_pkg::OP_PUSH, 3'd1, 32'h1234_5678, 1,  1'b1,
          '{32'h0, 3'd0, kmwt_pkg::ST_RANGE}},
        '{ROW_REQ, kmwt_pkg::OP_POP,  3'd0, 32'h0000_0000, 1,  1'b1,
          '{32'h0, 3'd0, kmwt_pkg::ST_EMPTY}},
        '{ROW_REQ, kmwt_pkg::OP_PUSH, 3'd0, 32'h5555_5555, 16, 1'b0,
          '{32'h0, 3'd0, kmwt_pkg::ST_OK}},
        '{ROW_REQ, kmwt_pkg::OP_PUSH, 3'd0, 32'h0000_0000, 1,  1'b1,
          '{32'h0, 3'd0, kmwt_pkg::ST_FULL}},
        '{ROW_CFG, kmwt_pkg::OP_PUSH, 3'd0, 32'd15,        1,  1'b0,
          '{32'h0, 3'd0, kmwt_pkg::ST_OK}},
        '{ROW_REQ, kmwt_pkg::OP_POP,  3'd0, 32'h0000_0000, 1,  1'b0,
          '{32'h0, 3'd0, kmwt_pkg::ST_OK}},
        '{ROW_CFG, kmwt_pkg::OP_PUSH, 3'd0, 32'd8,         1,  1'b0,
          '{32'h0, 3'd0, kmwt_pkg::ST_OK}},
        '{ROW_REQ, kmwt_pkg::OP_POP,  3'd0, 32'h0000_0000, 1,  1'b0,
          '{32'h0, 3'd0, kmwt_pkg::ST_OK}}
    };

    logic                             i_clk         = 1'b0;
    logic                             i_rst_n       = 1'b0;
    logic                             i_cfg_valid   = 1'b0;
    logic                             o_cfg_ready;
    logic [kmwt_pkg::CFG_W-1:0]       i_cfg_data    = '0;
    logic                             s_axis_tvalid = 1'b0;
    logic                             s_axis_tready;
    logic [kmwt_pkg::IN_TDATA_W-1:0]  s_axis_tdata  = '0;   // way_index, value
    logic [kmwt_pkg::OP_W-1:0]        s_axis_tuser  = '0;   // operation
    logic                             m_axis_tvalid;
    logic                             m_axis_tready = 1'b0;
    logic [kmwt_pkg::OUT_TDATA_W-1:0] m_axis_tdata;  // merged_value, source_way, status

    // Predictor state: one FIFO per way and the way count register
    logic [kmwt_pkg::DATA_WIDTH-1:0]  way_data [kmwt_pkg::WAYS][kmwt_pkg::FIFO_DEPTH];
    int                               way_head [kmwt_pkg::WAYS];
    int                               way_fill [kmwt_pkg::WAYS];
    logic [kmwt_pkg::CFG_W-1:0]       model_ways;

    t_merge_result          pending_results [$];
    int                     gap_pct;
    int                     stall_pct;
    int                     next_gap;
    int                     error_count;
    int                     result_count;
    int                     push_count;
    int                     pop_count;
    int                     full_count;
    int                     empty_count;
    int                     range_count;
    int                     cfg_count;

    kway_merge_winner_tree dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // Clamp the register to the ways that can actually take part
    function automatic int active_ways();
        int act;
        act = int'(model_ways);
        if (act < 1) act = 1;
        if (act > kmwt_pkg::WAYS) act = kmwt_pkg::WAYS;
        return act;
    endfunction

    // Apply one request to the predictor and return its result
    function automatic t_merge_result merge_predict(kmwt_pkg::t_op op,
                                                    logic [kmwt_pkg::IN_WAY_W-1:0] way,
                                                    logic [kmwt_pkg::VAL_W-1:0] val);
        t_merge_result res;
        int act;
        int best;
        int slot;
        res = '{'0, '0, kmwt_pkg::ST_OK};
        act = active_ways();
        if (op == kmwt_pkg::OP_PUSH) begin
            if (int'(way) >= act) begin
                res.status = kmwt_pkg::ST_RANGE;
            end else if (way_fill[way] >= kmwt_pkg::FIFO_DEPTH) begin
                res.status = kmwt_pkg::ST_FULL;
            end else begin
                slot = (way_head[way] + way_fill[way]) % kmwt_pkg::FIFO_DEPTH;
                way_data[way][slot] = val;
                way_fill[way]++;
            end
        end else begin
            // smallest head wins; strict compare keeps the lower way on a tie
            best = -1;
            for (int w = 0; w < act; w++) begin
                if (way_fill[w] != 0 && (best < 0 ||
                    $signed(way_data[w][way_head[w]]) <
                    $signed(way_data[best][way_head[best]]))) begin
                    best = w;
                end
            end
            if (best < 0) begin
                res.status = kmwt_pkg::ST_EMPTY;
            end else begin
                res.value = way_data[best][way_head[best]];
                res.way = kmwt_pkg::OUT_WAY_W'(best);
                way_head[best] = (way_head[best] + 1) % kmwt_pkg::FIFO_DEPTH;
                way_fill[best]--;
            end
        end
        return res;
    endfunction

    function automatic int pick_gap();
        if ($urandom_range(0, 99) < gap_pct) begin
            return $urandom_range(1, 4);
        end
        return 0;
    endfunction

    function automatic logic [kmwt_pkg::VAL_W-1:0] rand_value();
        logic [kmwt_pkg::VAL_W-1:0] v;
        case ($urandom_range(0, 9))
            0, 1, 2, 3: v = kmwt_pkg::VAL_W'($urandom_range(0, 16)) - kmwt_pkg::VAL_W'(8);
            4: begin
                case ($urandom_range(0, 3))
                    0: v = 32'h8000_0000;
                    1: v = 32'h7FFF_FFFF;
                    2: v = 32'h0000_0000;
                    default: v = 32'hFFFF_FFFF;
                endcase
            end
            default: v = $urandom;
        endcase
        return v;
    endfunction

    function automatic void set_idle_mode(t_idle_mode mode);
        case (mode)
            IDLE_SENDER: begin
                gap_pct = 75;
                stall_pct = 0;
            end
            IDLE_RECEIVER: begin
                gap_pct = 0;
                stall_pct = 75;
            end
            IDLE_BOTH: begin
                gap_pct = 28;
                stall_pct = 28;
            end
            default: begin
                gap_pct = 0;
                stall_pct = 0;
            end
        endcase
    endfunction

    // Drain outstanding results, then write the way count register
    task automatic write_way_count(logic [kmwt_pkg::CFG_W-1:0] v);
        while (pending_results.size() != 0) @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data <= v;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        model_ways = v;
        cfg_count++;
    endtask

    // Offer one request; keep tvalid high into the next one unless it is the last or a gap follows
    task automatic send_request(kmwt_pkg::t_op op, logic [kmwt_pkg::IN_WAY_W-1:0] way,
                                logic [kmwt_pkg::VAL_W-1:0] val,
                                bit last, bit typed, t_merge_result typed_exp);
        t_merge_result exp;
        repeat (next_gap) @(posedge i_clk);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= kmwt_pkg::IN_TDATA_W'({val, way});
        s_axis_tuser <= op;
        do @(posedge i_clk); while (!s_axis_tready);
        exp = merge_predict(op, way, val);
        if (typed) exp = typed_exp;
        pending_results.push_back(exp);
        if (op == kmwt_pkg::OP_PUSH) push_count++;
        else pop_count++;
        case (exp.status)
            kmwt_pkg::ST_FULL:  full_count++;
            kmwt_pkg::ST_EMPTY: empty_count++;
            kmwt_pkg::ST_RANGE: range_count++;
            default: ;
        endcase
        next_gap = pick_gap();
        if (last || next_gap != 0) s_axis_tvalid <= 1'b0;
    endtask

    function automatic void note_mismatch(string what, logic [kmwt_pkg::VAL_W-1:0] exp_v,
                                          logic [kmwt_pkg::VAL_W-1:0] got_v);
        error_count++;
        if (error_count <= 10) begin
            $display("result %0d: %s expected %h got %h", result_count, what, exp_v, got_v);
        end
    endfunction

    // Check each taken result against the oldest expectation; set the next stall
    always @(posedge i_clk) begin
        t_merge_result exp;
        t_merge_result got;
        if (m_axis_tvalid && m_axis_tready) begin
            got.value  = m_axis_tdata[kmwt_pkg::VAL_W-1:0];
            got.way    = m_axis_tdata[kmwt_pkg::VAL_W +: kmwt_pkg::OUT_WAY_W];
            got.status = kmwt_pkg::t_status'(
                m_axis_tdata[kmwt_pkg::VAL_W+kmwt_pkg::OUT_WAY_W +: kmwt_pkg::STAT_W]);
            if (pending_results.size() == 0) begin
                note_mismatch("unexpected result, tdata", '0, got.value);
            end else begin
                exp = pending_results.pop_front();
                if (got.value !== exp.value) note_mismatch("merged_value", exp.value, got.value);
                if (got.way !== exp.way) note_mismatch("source_way",
                                                       kmwt_pkg::VAL_W'(exp.way),
                                                       kmwt_pkg::VAL_W'(got.way));
                if (got.status !== exp.status) note_mismatch("status",
                                                             kmwt_pkg::VAL_W'(exp.status),
                                                             kmwt_pkg::VAL_W'(got.status));
            end
            result_count++;
        end
        m_axis_tready <= ($urandom_range(0, 99) >= stall_pct);
    end

    // Watchdog
    initial begin
        #2_000_000;
        $display("kway_merge_winner_tree: mismatch");
        $finish;
    end

    initial begin
        kmwt_pkg::t_op op;
        logic [kmwt_pkg::IN_WAY_W-1:0] way;
        logic [kmwt_pkg::VAL_W-1:0] val;
        bit last;
        int act;

        for (int w = 0; w < kmwt_pkg::WAYS; w++) begin
            way_head[w] = 0;
            way_fill[w] = 0;
            for (int s = 0; s < kmwt_pkg::FIFO_DEPTH; s++) way_data[w][s] = '0;
        end
        model_ways = kmwt_pkg::CFG_W'(kmwt_pkg::CFG_RESET);
        next_gap = 0;
        error_count = 0;
        result_count = 0;
        push_count = 0;
        pop_count = 0;
        full_count = 0;
        empty_count = 0;
        range_count = 0;
        cfg_count = 0;
        set_idle_mode(IDLE_NONE);

        // hold reset, then release it
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed rows
        for (int r = 0; r < N_ROWS; r++) begin
            if (plan_rows[r].kind == ROW_CFG) begin
                write_way_count(plan_rows[r].value[kmwt_pkg::CFG_W-1:0]);
            end else begin
                for (int k = 0; k < plan_rows[r].reps; k++) begin
                    last = (k == plan_rows[r].reps - 1) &&
                           (r == N_ROWS - 1 || plan_rows[r+1].kind == ROW_CFG);
                    send_request(plan_rows[r].op, plan_rows[r].way, plan_rows[r].value,
                                 last, plan_rows[r].typed, plan_rows[r].exp);
                end
            end
        end

        // random phases, each with its own way count, push mix and idling
        for (int p = 0; p < N_PHASES; p++) begin
            write_way_count(kmwt_pkg::CFG_W'(PHASE_WAYS[p]));
            set_idle_mode(t_idle_mode'(p % 4));
            next_gap = 0;
            act = active_ways();
            for (int i = 0; i < PHASE_ITEMS; i++) begin
                if ($urandom_range(0, 99) < PHASE_PUSH[p]) begin
                    op = kmwt_pkg::OP_PUSH;
                    if ($urandom_range(0, 99) < 8) begin
                        way = kmwt_pkg::IN_WAY_W'($urandom_range(0, 7));
                    end else begin
                        way = kmwt_pkg::IN_WAY_W'($urandom_range(0, act - 1));
                    end
                    val = rand_value();
                end else begin
                    op = kmwt_pkg::OP_POP;
                    way = kmwt_pkg::IN_WAY_W'($urandom_range(0, 7));
                    val = $urandom;
                end
                send_request(op, way, val, i == PHASE_ITEMS - 1, 1'b0,
                             '{'0, '0, kmwt_pkg::ST_OK});
            end
        end

        // wait for the last results, then a settling stretch
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);

        $display("Ran %0d pushes and %0d pops over %0d way-count writes, %0d results taken.",
                 push_count, pop_count, cfg_count, result_count);
        $display("Full drops %0d, empty pops %0d, out-of-range pushes %0d, errors %0d.",
                 full_count, empty_count, range_count, error_count);
        if (error_count == 0) begin
            $display("kway_merge_winner_tree: match");
        end else begin
            $display("kway_merge_winner_tree: mismatch");
        end
        $finish;
    end

endmodule
